// File: rtl/core/bit_pkg.sv
// ----------------------------------------------------------------------------
// bit_pkg
// Shared types and constants of the brush image transform core.
// ----------------------------------------------------------------------------
`default_nettype none
package bit_pkg;

  localparam int MAX_DIM    = 64;
  localparam int MAX_PIXELS = 4096;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int HOT_W      = $clog2(MAX_DIM);
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int PIX_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DAT_W  = 7;

  localparam logic [PIX_W-1:0] PIX_CLEAR = '1;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_FLIP    = 3'd2,
    CMD_ROTATE  = 3'd3,
    CMD_SET_TR  = 3'd4,
    CMD_RECOLOR = 3'd5,
    CMD_CHECK   = 3'd6,
    CMD_READ    = 3'd7
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_HOT_X    = 3'd2,
    REG_HOT_Y    = 3'd3,
    REG_CENTERED = 3'd4,
    REG_SHAPE    = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_PERM,
    ST_MAP,
    ST_CHECK
  } state_t;

  typedef enum logic [2:0] {
    SRC_LINEAR,
    SRC_FLIP_H,
    SRC_FLIP_V,
    SRC_CW,
    SRC_CCW
  } src_mode_t;

  typedef struct packed {
    logic             start;
    src_mode_t        mode;
    logic [DIM_W-1:0] cols;
  } scan_ctrl_t;

  typedef struct packed {
    logic              issue;
    logic              last;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
  } scan_out_t;

endpackage
`default_nettype wire

// File: rtl/core/brush_image_transform_core.sv
// ----------------------------------------------------------------------------
// brush_image_transform_core
// Indexed-colour brush image with load, flip, rotate, recolour and checks.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: cfg_index/cfg_data written at a cfg_valid/cfg_ready transfer,
//   always ready; write only while the core is idle.
//   in channel: one command per transfer; out channel: one result per command,
//   held in an output register until the receiver takes it.
//   A new command is taken only when the core is idle and the output register
//   is empty or being taken in the same cycle.
// Result path:
//   start, write pixel and the ignored transparent/recolour cases: result in
//   the cycle after the transfer.
//   read: a pixel memory read, then the output register.
//   transparent change, recolour: one read-modify-write pass over the pixel
//   memory; single check: one read pass over the pixel memory.
//   flip, rotate: a copy pass into the scratch memory and a permuting pass back.
// Reset: size 16 x 16, hotspot 0, transparent -1, write pointer 0; the pixel
// memories are not cleared. A stalled receiver holds the core after the
// current command.
// ----------------------------------------------------------------------------
`default_nettype none
module brush_image_transform_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bit_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [2:0]                     cmd,
  input  wire logic signed [8:0]              pixel_value,
  input  wire logic                           flip_vertical,
  input  wire logic                           rotate_ccw,
  input  wire logic [11:0]                    pixel_index,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [8:0]                   read_value,
  output logic                                single_color,
  output logic [6:0]                          cur_width,
  output logic [6:0]                          cur_height,
  output logic [5:0]                          cur_hotspot_x,
  output logic [5:0]                          cur_hotspot_y,
  output logic                                status
);

  localparam int DW = bit_pkg::DIM_W;
  localparam int HW = bit_pkg::HOT_W;
  localparam int AW = bit_pkg::ADDR_W;
  localparam int CW = bit_pkg::CNT_W;
  localparam int PW = bit_pkg::PIX_W;

  // configuration registers
  logic [DW-1:0] cfg_w, cfg_h;
  logic [HW-1:0] cfg_hx, cfg_hy;
  logic          cfg_center, cfg_shape;

  // block state
  bit_pkg::state_t    state, state_next;
  logic [DW-1:0]      width_now, width_now_next, height_now, height_now_next;
  logic [HW-1:0]      hot_x, hot_x_next, hot_y, hot_y_next;
  logic [PW-1:0]      transp, transp_next;
  logic [CW-1:0]      wptr, wptr_next, area_now, area_now_next;

  // command held during a pass
  bit_pkg::cmd_t      cmd_q, cmd_q_next;
  logic [PW-1:0]      val_q, val_q_next;
  bit_pkg::src_mode_t mode_q, mode_q_next;
  logic               rd_bad, rd_bad_next;

  // second pass stage
  logic               s_vld, s_vld_next, s_last, s_last_next;
  logic [AW-1:0]      s_dst, s_dst_next;
  logic               seen, seen_next, single, single_next;
  logic [PW-1:0]      col, col_next;

  // output register
  logic               o_vld, o_vld_next;
  logic [PW-1:0]      o_rd, o_rd_next;
  logic               o_single, o_single_next, o_status, o_status_next;
  logic [DW-1:0]      o_w, o_w_next, o_h, o_h_next;
  logic [HW-1:0]      o_hx, o_hx_next, o_hy, o_hy_next;

  // memory ports
  logic               pix_we, pix_re, scr_we, scr_re;
  logic [AW-1:0]      pix_waddr, pix_raddr, scr_waddr, scr_raddr;
  logic [PW-1:0]      pix_wdata, pix_rdata, scr_wdata, scr_rdata;

  bit_pkg::scan_ctrl_t scan_ctrl;
  bit_pkg::scan_out_t  scan;

  logic                  accept;
  logic [2*DW-1:0]       start_area;
  logic                  start_bad;
  logic                  emit;
  logic [PW-1:0]         mapped;

  bit_ram #(.DEPTH(bit_pkg::MAX_PIXELS), .WIDTH(PW)) u_pix (
    .clk(clk), .we(pix_we), .waddr(pix_waddr), .wdata(pix_wdata),
    .re(pix_re), .raddr(pix_raddr), .rdata(pix_rdata)
  );

  bit_ram #(.DEPTH(bit_pkg::MAX_PIXELS), .WIDTH(PW)) u_scr (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .re(scr_re), .raddr(scr_raddr), .rdata(scr_rdata)
  );

  bit_scan u_scan (
    .clk(clk), .rst(rst), .ctrl(scan_ctrl), .width_now(width_now),
    .height_now(height_now), .area(area_now), .scan(scan)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == bit_pkg::ST_IDLE) && (!o_vld || out_ready);
  assign accept    = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w      <= DW'(16);
      cfg_h      <= DW'(16);
      cfg_hx     <= '0;
      cfg_hy     <= '0;
      cfg_center <= 1'b1;
      cfg_shape  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bit_pkg::REG_WIDTH:    cfg_w      <= cfg_data[DW-1:0];
        bit_pkg::REG_HEIGHT:   cfg_h      <= cfg_data[DW-1:0];
        bit_pkg::REG_HOT_X:    cfg_hx     <= cfg_data[HW-1:0];
        bit_pkg::REG_HOT_Y:    cfg_hy     <= cfg_data[HW-1:0];
        bit_pkg::REG_CENTERED: cfg_center <= cfg_data[0];
        bit_pkg::REG_SHAPE:    cfg_shape  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // start size check
  assign start_area = cfg_w * cfg_h;
  assign start_bad  = (cfg_w == '0) || (cfg_w > DW'(bit_pkg::MAX_DIM)) ||
                      (cfg_h == '0) || (cfg_h > DW'(bit_pkg::MAX_DIM)) ||
                      (start_area > (2*DW)'(bit_pkg::MAX_PIXELS));

  // transparent change and recolour of one pixel
  always_comb begin
    mapped = pix_rdata;
    if (cmd_q == bit_pkg::CMD_SET_TR) begin
      if (pix_rdata == bit_pkg::PIX_CLEAR) begin
        mapped = transp;
      end else if (pix_rdata == val_q) begin
        mapped = bit_pkg::PIX_CLEAR;
      end
    end else if (pix_rdata != bit_pkg::PIX_CLEAR) begin
      mapped = val_q;
    end
  end

  // next state and datapath control
  always_comb begin
    state_next      = state;
    width_now_next  = width_now;
    height_now_next = height_now;
    hot_x_next      = hot_x;
    hot_y_next      = hot_y;
    transp_next     = transp;
    wptr_next       = wptr;
    area_now_next   = area_now;
    cmd_q_next      = cmd_q;
    val_q_next      = val_q;
    mode_q_next     = mode_q;
    rd_bad_next     = rd_bad;
    s_vld_next      = scan.issue;
    s_last_next     = scan.last;
    s_dst_next      = scan.dst;
    seen_next       = seen;
    single_next     = single;
    col_next        = col;
    o_vld_next      = o_vld && !out_ready;
    o_rd_next       = o_rd;
    o_single_next   = o_single;
    o_status_next   = o_status;
    o_w_next        = o_w;
    o_h_next        = o_h;
    o_hx_next       = o_hx;
    o_hy_next       = o_hy;
    emit            = 1'b0;
    scan_ctrl       = '{start: 1'b0, mode: bit_pkg::SRC_LINEAR, cols: width_now};
    pix_we          = 1'b0;
    pix_waddr       = s_dst;
    pix_wdata       = scr_rdata;
    pix_re          = 1'b0;
    pix_raddr       = scan.dst;
    scr_we          = 1'b0;
    scr_waddr       = s_dst;
    scr_wdata       = pix_rdata;
    scr_re          = 1'b0;
    scr_raddr       = scan.src;

    case (state)
      bit_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_q_next    = bit_pkg::cmd_t'(cmd);
          val_q_next    = pixel_value;
          o_rd_next     = '0;
          o_single_next = 1'b0;
          o_status_next = 1'b0;
          case (bit_pkg::cmd_t'(cmd))
            bit_pkg::CMD_START: begin
              emit          = 1'b1;
              o_status_next = start_bad;
              if (!start_bad) begin
                width_now_next  = cfg_w;
                height_now_next = cfg_h;
                area_now_next   = start_area[CW-1:0];
                hot_x_next      = cfg_center ? cfg_w[DW-1:1] : cfg_hx;
                hot_y_next      = cfg_center ? cfg_h[DW-1:1] : cfg_hy;
                transp_next     = pixel_value;
                wptr_next       = '0;
              end
            end
            bit_pkg::CMD_WRITE: begin
              emit = 1'b1;
              if (wptr < area_now) begin
                pix_we    = 1'b1;
                pix_waddr = wptr[AW-1:0];
                pix_wdata = pixel_value;
                wptr_next = wptr + CW'(1);
              end else begin
                o_status_next = 1'b1;
              end
            end
            bit_pkg::CMD_FLIP, bit_pkg::CMD_ROTATE: begin
              if (bit_pkg::cmd_t'(cmd) == bit_pkg::CMD_FLIP) begin
                mode_q_next = flip_vertical ? bit_pkg::SRC_FLIP_V : bit_pkg::SRC_FLIP_H;
              end else begin
                mode_q_next = rotate_ccw ? bit_pkg::SRC_CCW : bit_pkg::SRC_CW;
              end
              scan_ctrl.start = 1'b1;
              state_next      = bit_pkg::ST_COPY;
            end
            bit_pkg::CMD_SET_TR: begin
              if (cfg_shape || (pixel_value == transp)) begin
                emit = 1'b1;
              end else begin
                scan_ctrl.start = 1'b1;
                state_next      = bit_pkg::ST_MAP;
              end
            end
            bit_pkg::CMD_RECOLOR: begin
              if (!cfg_shape) begin
                emit = 1'b1;
              end else begin
                scan_ctrl.start = 1'b1;
                state_next      = bit_pkg::ST_MAP;
              end
            end
            bit_pkg::CMD_CHECK: begin
              seen_next       = 1'b0;
              single_next     = 1'b1;
              scan_ctrl.start = 1'b1;
              state_next      = bit_pkg::ST_CHECK;
            end
            default: begin
              pix_re      = 1'b1;
              pix_raddr   = pixel_index;
              rd_bad_next = ({1'b0, pixel_index} >= area_now);
              state_next  = bit_pkg::ST_READ;
            end
          endcase
        end
      end

      bit_pkg::ST_READ: begin
        emit          = 1'b1;
        o_rd_next     = rd_bad ? '0 : pix_rdata;
        o_status_next = rd_bad;
        state_next    = bit_pkg::ST_IDLE;
      end

      // copy the image into scratch, then permute it back
      bit_pkg::ST_COPY: begin
        pix_re = scan.issue;
        scr_we = s_vld;
        if (s_vld && s_last) begin
          scan_ctrl.start = 1'b1;
          scan_ctrl.mode  = mode_q;
          scan_ctrl.cols  = (mode_q == bit_pkg::SRC_CW || mode_q == bit_pkg::SRC_CCW)
                            ? height_now : width_now;
          state_next      = bit_pkg::ST_PERM;
        end
      end

      bit_pkg::ST_PERM: begin
        scr_re = scan.issue;
        pix_we = s_vld;
        if (s_vld && s_last) begin
          if (cmd_q == bit_pkg::CMD_ROTATE) begin
            width_now_next  = height_now;
            height_now_next = width_now;
            hot_x_next      = hot_y;
            hot_y_next      = hot_x;
          end
          emit       = 1'b1;
          state_next = bit_pkg::ST_IDLE;
        end
      end

      // read-modify-write pass
      bit_pkg::ST_MAP: begin
        pix_re    = scan.issue;
        pix_we    = s_vld;
        pix_wdata = mapped;
        if (s_vld && s_last) begin
          if (cmd_q == bit_pkg::CMD_SET_TR) begin
            transp_next = val_q;
          end
          emit       = 1'b1;
          state_next = bit_pkg::ST_IDLE;
        end
      end

      bit_pkg::ST_CHECK: begin
        pix_re = scan.issue;
        if (s_vld && (pix_rdata != bit_pkg::PIX_CLEAR)) begin
          if (!seen) begin
            seen_next = 1'b1;
            col_next  = pix_rdata;
          end else if (pix_rdata != col) begin
            single_next = 1'b0;
          end
        end
        if (s_vld && s_last) begin
          emit          = 1'b1;
          o_single_next = single_next;
          state_next    = bit_pkg::ST_IDLE;
        end
      end

      default: state_next = bit_pkg::ST_IDLE;
    endcase

    // load the result with the state it leaves
    if (emit) begin
      o_vld_next = 1'b1;
      o_w_next   = width_now_next;
      o_h_next   = height_now_next;
      o_hx_next  = hot_x_next;
      o_hy_next  = hot_y_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bit_pkg::ST_IDLE;
      width_now  <= DW'(16);
      height_now <= DW'(16);
      hot_x      <= '0;
      hot_y      <= '0;
      transp     <= bit_pkg::PIX_CLEAR;
      wptr       <= '0;
      area_now   <= CW'(256);
      s_vld      <= 1'b0;
      o_vld      <= 1'b0;
    end else begin
      state      <= state_next;
      width_now  <= width_now_next;
      height_now <= height_now_next;
      hot_x      <= hot_x_next;
      hot_y      <= hot_y_next;
      transp     <= transp_next;
      wptr       <= wptr_next;
      area_now   <= area_now_next;
      s_vld      <= s_vld_next;
      o_vld      <= o_vld_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_q    <= cmd_q_next;
    val_q    <= val_q_next;
    mode_q   <= mode_q_next;
    rd_bad   <= rd_bad_next;
    s_last   <= s_last_next;
    s_dst    <= s_dst_next;
    seen     <= seen_next;
    single   <= single_next;
    col      <= col_next;
    o_rd     <= o_rd_next;
    o_single <= o_single_next;
    o_status <= o_status_next;
    o_w      <= o_w_next;
    o_h      <= o_h_next;
    o_hx     <= o_hx_next;
    o_hy     <= o_hy_next;
  end

  assign out_valid     = o_vld;
  assign read_value    = o_rd;
  assign single_color  = o_single;
  assign status        = o_status;
  assign cur_width     = o_w;
  assign cur_height    = o_h;
  assign cur_hotspot_x = o_hx;
  assign cur_hotspot_y = o_hy;

endmodule
`default_nettype wire

// File: rtl/core/bit_ram.sv
// ----------------------------------------------------------------------------
// bit_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module bit_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 9,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bit_scan.sv
// ----------------------------------------------------------------------------
// bit_scan
// Pass sequencer: walks destination pixels in row order and forms the
// source address of each for linear, flip and rotate passes.
// ----------------------------------------------------------------------------
`default_nettype none
module bit_scan (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bit_pkg::scan_ctrl_t         ctrl,
  input  wire logic [bit_pkg::DIM_W-1:0]   width_now,
  input  wire logic [bit_pkg::DIM_W-1:0]   height_now,
  input  wire logic [bit_pkg::CNT_W-1:0]   area,
  output bit_pkg::scan_out_t               scan
);

  logic                        active;
  logic [bit_pkg::CNT_W-1:0]   d;
  logic [bit_pkg::DIM_W-1:0]   o;
  logic [bit_pkg::DIM_W-1:0]   k;
  bit_pkg::src_mode_t          mode;
  logic [bit_pkg::DIM_W-1:0]   cols;
  logic                        last;
  logic [bit_pkg::DIM_W-1:0]   op_a;
  logic [bit_pkg::DIM_W-1:0]   op_b;
  logic [2*bit_pkg::DIM_W-1:0] prod;
  logic [2*bit_pkg::DIM_W-1:0] sum;

  assign last = (d == area - bit_pkg::CNT_W'(1));

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctrl.start) begin
      active <= 1'b1;
      d      <= '0;
      o      <= '0;
      k      <= '0;
      mode   <= ctrl.mode;
      cols   <= ctrl.cols;
    end else if (active) begin
      if (last) begin
        active <= 1'b0;
      end
      d <= d + bit_pkg::CNT_W'(1);
      if (k == cols - bit_pkg::DIM_W'(1)) begin
        k <= '0;
        o <= o + bit_pkg::DIM_W'(1);
      end else begin
        k <= k + bit_pkg::DIM_W'(1);
      end
    end
  end

  // source address as row times width plus column
  always_comb begin
    case (mode)
      bit_pkg::SRC_FLIP_H: begin
        op_a = o;
        op_b = width_now - bit_pkg::DIM_W'(1) - k;
      end
      bit_pkg::SRC_FLIP_V: begin
        op_a = height_now - bit_pkg::DIM_W'(1) - o;
        op_b = k;
      end
      bit_pkg::SRC_CW: begin
        op_a = height_now - bit_pkg::DIM_W'(1) - k;
        op_b = o;
      end
      bit_pkg::SRC_CCW: begin
        op_a = k;
        op_b = width_now - bit_pkg::DIM_W'(1) - o;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod = op_a * width_now;
    sum  = prod + {{bit_pkg::DIM_W{1'b0}}, op_b};
  end

  assign scan.issue = active;
  assign scan.last  = last;
  assign scan.dst   = d[bit_pkg::ADDR_W-1:0];
  assign scan.src   = (mode == bit_pkg::SRC_LINEAR) ? d[bit_pkg::ADDR_W-1:0]
                                                    : sum[bit_pkg::ADDR_W-1:0];

endmodule
`default_nettype wire

// File: rtl/core/bit_checker.sv
// ----------------------------------------------------------------------------
// bit_checker
// Port-level assertions of the brush image transform core.
// ----------------------------------------------------------------------------
`default_nettype none
module bit_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [8:0] read_value,
  input wire logic              single_color,
  input wire logic [6:0]        cur_width,
  input wire logic [6:0]        cur_height,
  input wire logic              status
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its pixel value
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(read_value))
    else $error("read value changed while stalled");

  // the image never has a zero dimension
  a_size: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cur_width != 7'd0) && (cur_height != 7'd0))
    else $error("zero image dimension");

  // a rejected transfer carries no pixel and no check flag
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (read_value == 9'sd0) && !single_color)
    else $error("rejected result carries data");

endmodule

bind brush_image_transform_core bit_checker u_bit_checker (.*);
`default_nettype wire
